/* hw/rtl/desa_pkg.sv */
// Shared types and codes for the double-ended stack allocator.
`default_nettype none

package desa_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] POOL_SIZE_RESET = 32'd29913024;

    localparam logic [MODE_W-1:0] MODE_ALLOC_LO  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC_LO32 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ALLOC_HI  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOCK      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_UNWIND    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RELEASE   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_QUERY     = 3'd6;
    localparam logic [MODE_W-1:0] MODE_INIT      = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_RESERVED = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_SPACE = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_SLOT = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_ROOM  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED     = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] size;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0]        address;
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] bytes_free;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/double_ended_stack_allocator_core.sv */
// Top level of the double-ended stack allocator: command stage, execute stage, lock memory.
//
// Usage:
//   Commands enter on i_cmd when start is high and busy is low. Each command gives
//   exactly one item on o_result, marked by o_result_valid for one cycle; the
//   receiver cannot stall it, so it must take every item as it appears.
//   An accepted command is captured in the input register and executed into the
//   result register, which drives o_result and o_result_valid.
//   Throughput: one command per cycle while busy is low. The input register
//   captures the command and the lock-slot memory read; the execute stage
//   updates the marks and the result register, with a bypass for a lock
//   followed directly by a read of the same slot.
//   Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
//   index 0 base address, 1 pool size, 2 reserved flag. Write only while idle.
//   Reset (i_rst_n low, synchronous): busy is high, marks return to low = 0,
//   high = pool size reset value, high total = 0, all lock slots read as zero
//   through per-slot valid bits. busy clears when clocked with i_rst_n high.
`default_nettype none

module double_ended_stack_allocator_core #(
    parameter int unsigned LOCK_SLOTS = 8
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  desa_pkg::t_cmd                       i_cmd,
    output logic                                 o_result_valid,
    output desa_pkg::t_result                    o_result,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [desa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [desa_pkg::DATA_W-1:0]          i_cfg_data
);

    localparam int unsigned IW = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;

    logic [31:0] r_base;
    logic [31:0] r_pool_size;
    logic        r_reserved;

    logic [31:0] r_low,   n_low;
    logic [31:0] r_high,  n_high;
    logic [31:0] r_total, n_total;
    logic [LOCK_SLOTS-1:0] r_slot_vld, n_slot_vld;

    logic [31:0] mem_slots [LOCK_SLOTS];

    logic            r_busy;
    logic            r_vld;
    desa_pkg::t_cmd  r_cmd;
    logic [31:0]     r_rd_data;
    logic            r_fwd;
    logic [31:0]     r_fwd_data;

    logic              r_res_vld;
    desa_pkg::t_result r_result, n_result;

    logic          accept;
    logic          in_rng_i;
    logic [IW-1:0] idx_i;
    logic          in_rng;
    logic [IW-1:0] idx;
    logic          lock_we;
    logic [31:0]   entry;

    logic [32:0]        need_a;
    logic [4:0]         pad;
    logic [32:0]        req_b;
    logic [33:0]        need_b;
    logic [33:0]        need_l;
    logic signed [33:0] avail;
    logic               no_room;
    logic               fits;
    logic [31:0]        addr_l;
    logic [31:0]        top;
    logic [31:0]        blk_start;
    logic [31:0]        taken;

    assign busy        = r_busy;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign in_rng_i = int'(i_cmd.slot) < int'(LOCK_SLOTS);
    assign idx_i    = IW'(i_cmd.slot);
    assign in_rng   = int'(r_cmd.slot) < int'(LOCK_SLOTS);
    assign idx      = IW'(r_cmd.slot);
    assign lock_we  = r_vld && (r_cmd.mode == desa_pkg::MODE_LOCK) && in_rng;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_pool_size <= desa_pkg::POOL_SIZE_RESET;
            r_reserved  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                desa_pkg::CFG_BASE_ADDRESS: r_base      <= i_cfg_data;
                desa_pkg::CFG_POOL_SIZE:    r_pool_size <= i_cfg_data;
                desa_pkg::CFG_RESERVED:     r_reserved  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (lock_we) begin
            mem_slots[idx] <= r_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && in_rng_i) begin
            r_rd_data <= mem_slots[idx_i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= i_cmd;
            r_fwd      <= lock_we && in_rng_i && (idx == idx_i);
            r_fwd_data <= r_low;
        end
    end

    always_comb begin
        entry = '0;
        if (in_rng && r_slot_vld[idx]) begin
            entry = r_fwd ? r_fwd_data : r_rd_data;
        end
    end

    always_comb begin
        need_a    = ({1'b0, r_cmd.size} + 33'h0f) & ~33'h0f;
        pad       = 5'(5'd0 - r_low[4:0]);
        req_b     = {1'b0, r_cmd.size} + 33'(pad);
        need_b    = ({1'b0, req_b} + 34'h0f) & ~34'h0f;
        avail     = $signed({2'b00, r_high}) - $signed({2'b00, r_low});
        no_room   = avail < $signed({1'b0, req_b});
        need_l    = (r_cmd.mode == desa_pkg::MODE_ALLOC_LO32) ? need_b : {1'b0, need_a};
        fits      = ({2'b00, r_low} + need_l) <= {2'b00, r_high};
        addr_l    = r_base + {r_low[31:2], 2'b00}
                  + ((r_cmd.mode == desa_pkg::MODE_ALLOC_LO32) ? 32'(pad) : 32'd0);
        top       = r_base + r_high - need_a[31:0];
        blk_start = {top[31:7], 7'b0};
        taken     = need_a[31:0] + 32'(top[6:0]);
    end

    always_comb begin
        n_low      = r_low;
        n_high     = r_high;
        n_total    = r_total;
        n_slot_vld = r_slot_vld;
        n_result.address = '0;
        n_result.status  = desa_pkg::ST_OK;
        unique case (r_cmd.mode) inside
            desa_pkg::MODE_ALLOC_LO, desa_pkg::MODE_ALLOC_LO32: begin
                if ((r_cmd.mode == desa_pkg::MODE_ALLOC_LO32) && no_room) begin
                    n_result.status = desa_pkg::ST_NO_ROOM;
                end else if (r_reserved) begin
                    n_result.status = desa_pkg::ST_RESERVED;
                end else if (!fits) begin
                    n_result.status = desa_pkg::ST_NO_SPACE;
                end else begin
                    n_result.address = addr_l;
                    n_low            = 32'(r_low + need_l[31:0]);
                end
            end
            desa_pkg::MODE_ALLOC_HI: begin
                if (r_reserved) begin
                    n_result.status = desa_pkg::ST_RESERVED;
                end else if (!fits) begin
                    n_result.status = desa_pkg::ST_NO_SPACE;
                end else begin
                    n_result.address = blk_start;
                    n_high           = r_high - taken;
                    n_total          = r_total + taken;
                end
            end
            desa_pkg::MODE_LOCK: begin
                if (!in_rng) begin
                    n_result.status = desa_pkg::ST_BAD_SLOT;
                end else begin
                    n_slot_vld[idx] = 1'b1;
                end
            end
            desa_pkg::MODE_UNWIND: begin
                if (!in_rng) begin
                    n_result.status = desa_pkg::ST_BAD_SLOT;
                end else begin
                    n_low = entry;
                    for (int i = 0; i < int'(LOCK_SLOTS); i++) begin
                        if (i > int'(r_cmd.slot)) begin
                            n_slot_vld[i] = 1'b0;
                        end
                    end
                end
            end
            desa_pkg::MODE_RELEASE: begin
                n_high  = r_high + r_total;
                n_total = '0;
            end
            desa_pkg::MODE_QUERY: ;
            desa_pkg::MODE_INIT: begin
                n_low      = '0;
                n_high     = r_pool_size;
                n_total    = '0;
                n_slot_vld = '0;
            end
            default: ;
        endcase
        n_result.bytes_free = $signed(n_high - n_low);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_vld      <= 1'b0;
            r_res_vld  <= 1'b0;
            r_low      <= '0;
            r_high     <= desa_pkg::POOL_SIZE_RESET;
            r_total    <= '0;
            r_slot_vld <= '0;
        end else begin
            r_busy    <= 1'b0;
            r_vld     <= accept;
            r_res_vld <= r_vld;
            if (r_vld) begin
                r_low      <= n_low;
                r_high     <= n_high;
                r_total    <= n_total;
                r_slot_vld <= n_slot_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld) begin
            r_result <= n_result;
        end
    end

    assign o_result_valid = r_res_vld;
    assign o_result       = r_result;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |=> o_result_valid)
        else $error("executed command produced no result");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status != desa_pkg::ST_OK)) |-> (o_result.address == '0))
        else $error("failed command returned an address");

    a_init_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && (r_cmd.mode == desa_pkg::MODE_INIT))
            |=> (o_result.bytes_free == $signed($past(r_pool_size))))
        else $error("init did not restore full pool");

    a_fail_keeps_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && (n_result.status != desa_pkg::ST_OK)) |=> $stable(r_low) && $stable(r_high))
        else $error("failed command changed the marks");

endmodule

`default_nettype wire

/* verif/tb_double_ended_stack_allocator_core.sv */
// Testbench for the double-ended stack allocator core: directed cases, random phases, checks.
module tb_double_ended_stack_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS   = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 40;

    localparam logic [desa_pkg::DATA_W-1:0] BLOCK_128_MASK = 32'hffff_ff80;
    localparam logic [desa_pkg::DATA_W-1:0] BASE_64_MASK   = 32'hffff_ffc0;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    desa_pkg::t_cmd                 i_cmd = '0;
    logic                           o_result_valid;
    desa_pkg::t_result              o_result;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [desa_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [desa_pkg::DATA_W-1:0]    i_cfg_data = '0;

    logic [desa_pkg::DATA_W-1:0] cfg_base = '0;
    logic [desa_pkg::DATA_W-1:0] cfg_pool = desa_pkg::POOL_SIZE_RESET;
    logic                        cfg_reserved = 1'b0;
    logic [desa_pkg::DATA_W-1:0] lo_mark;
    logic [desa_pkg::DATA_W-1:0] hi_mark;
    logic [desa_pkg::DATA_W-1:0] hi_total;
    logic [desa_pkg::DATA_W-1:0] lock_marks [NUM_SLOTS];

    desa_pkg::t_result pending_results [$];
    int                mismatches = 0;
    int                cycle_count = 0;

    double_ended_stack_allocator_core #(
        .LOCK_SLOTS(NUM_SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .o_result_valid(o_result_valid),
        .o_result      (o_result),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic void clear_marks();
        lo_mark  = '0;
        hi_mark  = cfg_pool;
        hi_total = '0;
        for (int i = 0; i < NUM_SLOTS; i++) lock_marks[i] = '0;
    endfunction

    function automatic logic [desa_pkg::STAT_W-1:0] take_low(
        input logic [63:0] n, output logic [desa_pkg::DATA_W-1:0] addr);
        logic [63:0] need;
        addr = '0;
        if (cfg_reserved) return desa_pkg::ST_RESERVED;
        need = (n + 64'hf) & ~64'hf;
        if ({32'd0, lo_mark} + need > {32'd0, hi_mark}) return desa_pkg::ST_NO_SPACE;
        addr = cfg_base + (lo_mark & 32'hffff_fffc);
        lo_mark = lo_mark + need[31:0];
        return desa_pkg::ST_OK;
    endfunction

    function automatic desa_pkg::t_result next_allocation(input desa_pkg::t_cmd c);
        desa_pkg::t_result           r;
        logic [63:0]                 need;
        logic [63:0]                 pad;
        logic signed [63:0]          avail;
        logic [desa_pkg::DATA_W-1:0] top;
        logic [desa_pkg::DATA_W-1:0] blk;
        logic [desa_pkg::DATA_W-1:0] taken;
        r.address = '0;
        r.status  = desa_pkg::ST_OK;
        case (c.mode)
            desa_pkg::MODE_ALLOC_LO: begin
                r.status = take_low({32'd0, c.size}, r.address);
            end
            desa_pkg::MODE_ALLOC_LO32: begin
                pad   = (({32'd0, lo_mark} + 64'h1f) & ~64'h1f) - {32'd0, lo_mark};
                avail = $signed({32'd0, hi_mark}) - $signed({32'd0, lo_mark});
                if (avail < $signed({32'd0, c.size} + pad)) begin
                    r.status = desa_pkg::ST_NO_ROOM;
                end else begin
                    r.status = take_low({32'd0, c.size} + pad, r.address);
                    if (r.status == desa_pkg::ST_OK) r.address = r.address + pad[31:0];
                    else r.address = '0;
                end
            end
            desa_pkg::MODE_ALLOC_HI: begin
                need = ({32'd0, c.size} + 64'hf) & ~64'hf;
                if (cfg_reserved) begin
                    r.status = desa_pkg::ST_RESERVED;
                end else if ({32'd0, lo_mark} + need > {32'd0, hi_mark}) begin
                    r.status = desa_pkg::ST_NO_SPACE;
                end else begin
                    top      = cfg_base + hi_mark - need[31:0];
                    blk      = top & BLOCK_128_MASK;
                    taken    = need[31:0] + (top - blk);
                    hi_mark  = hi_mark - taken;
                    hi_total = hi_total + taken;
                    r.address = blk;
                end
            end
            desa_pkg::MODE_LOCK: begin
                if (c.slot >= NUM_SLOTS) r.status = desa_pkg::ST_BAD_SLOT;
                else lock_marks[c.slot] = lo_mark;
            end
            desa_pkg::MODE_UNWIND: begin
                if (c.slot >= NUM_SLOTS) begin
                    r.status = desa_pkg::ST_BAD_SLOT;
                end else begin
                    lo_mark = lock_marks[c.slot];
                    for (int i = c.slot + 1; i < NUM_SLOTS; i++) lock_marks[i] = '0;
                end
            end
            desa_pkg::MODE_RELEASE: begin
                hi_mark  = hi_mark + hi_total;
                hi_total = '0;
            end
            desa_pkg::MODE_QUERY: begin
            end
            default: begin
                clear_marks();
            end
        endcase
        r.bytes_free = hi_mark - lo_mark;
        return r;
    endfunction

    always @(posedge i_clk) begin
        desa_pkg::t_result want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no command pending");
            end else begin
                want = pending_results.pop_front();
                if (o_result.address !== want.address)
                    report_mismatch($sformatf("address %h, want %h",
                                              o_result.address, want.address));
                if (o_result.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_result.status, want.status));
                if (o_result.bytes_free !== want.bytes_free)
                    report_mismatch($sformatf("bytes_free %0d, want %0d",
                                              o_result.bytes_free, want.bytes_free));
            end
        end
    end

    task automatic issue(input logic [desa_pkg::MODE_W-1:0] mode,
                         input logic [desa_pkg::DATA_W-1:0] size,
                         input logic [desa_pkg::SLOT_W-1:0] slot);
        desa_pkg::t_cmd c;
        c.mode = mode;
        c.size = size;
        c.slot = slot;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(next_allocation(c));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [desa_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [desa_pkg::DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            desa_pkg::CFG_BASE_ADDRESS: cfg_base = data;
            desa_pkg::CFG_POOL_SIZE:    cfg_pool = data;
            desa_pkg::CFG_RESERVED:     cfg_reserved = data[0];
            default: begin
            end
        endcase
    endtask

    function automatic desa_pkg::t_cmd random_command(input logic [desa_pkg::DATA_W-1:0] pool);
        desa_pkg::t_cmd c;
        int             pick;
        pick = $urandom_range(0, 99);
        if (pick < 22)      c.mode = desa_pkg::MODE_ALLOC_LO;
        else if (pick < 34) c.mode = desa_pkg::MODE_ALLOC_LO32;
        else if (pick < 52) c.mode = desa_pkg::MODE_ALLOC_HI;
        else if (pick < 64) c.mode = desa_pkg::MODE_LOCK;
        else if (pick < 74) c.mode = desa_pkg::MODE_UNWIND;
        else if (pick < 82) c.mode = desa_pkg::MODE_RELEASE;
        else if (pick < 92) c.mode = desa_pkg::MODE_QUERY;
        else if (pick < 95) c.mode = desa_pkg::MODE_INIT;
        else                c.mode = desa_pkg::MODE_ALLOC_LO;
        pick = $urandom_range(0, 99);
        if (pick < 55)      c.size = $urandom_range(0, 256);
        else if (pick < 75) c.size = $urandom_range(0, 4096);
        else if (pick < 85) c.size = pool >> $urandom_range(0, 4);
        else if (pick < 93) c.size = $urandom >> $urandom_range(0, 31);
        else                c.size = $urandom;
        if ($urandom_range(0, 9) == 0) c.slot = 4'($urandom_range(NUM_SLOTS, 15));
        else c.slot = 4'($urandom_range(0, NUM_SLOTS - 1));
        return c;
    endfunction

    task automatic run_phase(input logic [desa_pkg::DATA_W-1:0] base,
                             input logic [desa_pkg::DATA_W-1:0] pool,
                             input logic rsv, input int count, input bit gaps);
        desa_pkg::t_cmd c;
        drain();
        write_register(desa_pkg::CFG_BASE_ADDRESS, base & BASE_64_MASK);
        write_register(desa_pkg::CFG_POOL_SIZE, pool);
        write_register(desa_pkg::CFG_RESERVED, {31'd0, rsv});
        i_cfg_valid <= 1'b0;
        issue(desa_pkg::MODE_INIT, '0, '0);
        for (int n = 0; n < count; n++) begin
            if (gaps && $urandom_range(0, 5) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            c = random_command(pool);
            issue(c.mode, c.size, c.slot);
        end
    endtask

    task automatic test_reset_state();
        issue(desa_pkg::MODE_QUERY, '0, '0);
    endtask

    task automatic test_low_allocation();
        issue(desa_pkg::MODE_ALLOC_LO, 32'd0, '0);
        issue(desa_pkg::MODE_ALLOC_LO, 32'd1, '0);
        issue(desa_pkg::MODE_ALLOC_LO, 32'hffff_ffff, '0);
        issue(desa_pkg::MODE_ALLOC_LO32, 32'd5, '0);
        issue(desa_pkg::MODE_ALLOC_LO32, 32'hffff_ffff, '0);
    endtask

    task automatic test_high_allocation();
        issue(desa_pkg::MODE_ALLOC_HI, 32'd1, '0);
        issue(desa_pkg::MODE_ALLOC_HI, 32'hffff_ffff, '0);
        issue(desa_pkg::MODE_RELEASE, '0, '0);
    endtask

    task automatic test_lock_unwind();
        issue(desa_pkg::MODE_LOCK, '0, 4'd0);
        issue(desa_pkg::MODE_ALLOC_LO, 32'd100, '0);
        issue(desa_pkg::MODE_LOCK, '0, 4'd15);
        issue(desa_pkg::MODE_UNWIND, '0, 4'd8);
        issue(desa_pkg::MODE_UNWIND, '0, 4'd0);
        issue(desa_pkg::MODE_INIT, '0, '0);
    endtask

    task automatic test_reserved();
        drain();
        write_register(desa_pkg::CFG_RESERVED, 32'd1);
        i_cfg_valid <= 1'b0;
        issue(desa_pkg::MODE_ALLOC_LO, 32'd16, '0);
        issue(desa_pkg::MODE_ALLOC_LO32, 32'd16, '0);
        issue(desa_pkg::MODE_ALLOC_HI, 32'd16, '0);
        drain();
        write_register(desa_pkg::CFG_RESERVED, 32'd0);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_unwind_above_high();
        drain();
        write_register(desa_pkg::CFG_POOL_SIZE, 32'h100);
        i_cfg_valid <= 1'b0;
        issue(desa_pkg::MODE_INIT, '0, '0);
        issue(desa_pkg::MODE_ALLOC_LO, 32'h80, '0);
        issue(desa_pkg::MODE_LOCK, '0, 4'd0);
        issue(desa_pkg::MODE_UNWIND, '0, 4'd1);
        issue(desa_pkg::MODE_ALLOC_HI, 32'hc0, '0);
        issue(desa_pkg::MODE_UNWIND, '0, 4'd0);
    endtask

    task automatic test_high_wrap();
        drain();
        write_register(desa_pkg::CFG_BASE_ADDRESS, 32'h40);
        write_register(desa_pkg::CFG_POOL_SIZE, 32'h10);
        i_cfg_valid <= 1'b0;
        issue(desa_pkg::MODE_INIT, '0, '0);
        issue(desa_pkg::MODE_ALLOC_HI, 32'h10, '0);
    endtask

    task automatic test_random();
        run_phase(32'd0, desa_pkg::POOL_SIZE_RESET, 1'b0, 150, 1'b1);
        run_phase(BASE_64_MASK, 32'hffff_ffff, 1'b0, 150, 1'b1);
        run_phase($urandom, 32'd0, 1'b0, 60, 1'b1);
        run_phase($urandom, $urandom_range(0, 4096), 1'b0, 200, 1'b1);
        run_phase($urandom, $urandom_range(0, 4096), 1'b1, 60, 1'b1);
        run_phase($urandom, $urandom_range(0, 65535), 1'b0, 200, 1'b1);
        run_phase($urandom, $urandom_range(0, 8192), 1'b0, 200, 1'b0);
    endtask

    initial begin
        clear_marks();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_low_allocation();
        test_high_allocation();
        test_lock_unwind();
        test_reserved();
        test_unwind_above_high();
        test_high_wrap();
        test_random();
        drain();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/desa_pkg.sv
hw/rtl/double_ended_stack_allocator_core.sv
verif/tb_double_ended_stack_allocator_core.sv
